[sv/mm3_pkg.sv]
// Shared types, constants and microprogram for the streaming 128-bit hash.
// Used by mm3_engine, murmur3_128_stream_hash and the testbench; depends on nothing.
package mm3_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_low;
      logic [63:0] hash_high;
   } rsp_type;

   // Command from the front end to the engine
   typedef struct packed {
      logic mix;
      logic fin;
   } cmd_type;

   // Engine status back to the front end
   typedef struct packed {
      logic busy;
      logic fin_done;
   } status_type;

   // Mixing constants
   localparam logic [63:0] MIX_C1    = 64'h87c37b91114253d5;
   localparam logic [63:0] MIX_C2    = 64'h4cf5ab172f4541a9;
   localparam logic [63:0] FMIX_M1   = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_M2   = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] LANE1_ADD = 64'h0000000052dce729;
   localparam logic [63:0] LANE2_ADD = 64'h0000000038495ab5;

   // Microprogram layout
   localparam logic [5:0]  FIN_START = 6'd15;

   typedef enum logic [4:0] {
      OP_LOAD_K1,
      OP_LOAD_K2,
      OP_MUL_C1,
      OP_MUL_C2,
      OP_MUL_M1,
      OP_MUL_M2,
      OP_ROT31_K,
      OP_ROT33_K,
      OP_H1_MIX,
      OP_H2_MIX,
      OP_H1_X5,
      OP_H2_X5,
      OP_H1_ADD1,
      OP_H2_ADD2,
      OP_H1_XK,
      OP_H2_XK,
      OP_XLEN,
      OP_H1_ADD_H2,
      OP_H2_ADD_H1,
      OP_K_H1,
      OP_K_H2,
      OP_K_SHX,
      OP_H1_K,
      OP_H2_K,
      OP_END_MIX,
      OP_END_FIN
   } op_type;

   // Microprogram: block mix from 0, finalization from FIN_START
   function automatic op_type prog_op(input logic [5:0] pc);
      op_type op;
      case (pc)
         6'd0:  op = OP_LOAD_K1;
         6'd1:  op = OP_MUL_C1;
         6'd2:  op = OP_ROT31_K;
         6'd3:  op = OP_MUL_C2;
         6'd4:  op = OP_H1_MIX;
         6'd5:  op = OP_H1_X5;
         6'd6:  op = OP_H1_ADD1;
         6'd7:  op = OP_LOAD_K2;
         6'd8:  op = OP_MUL_C2;
         6'd9:  op = OP_ROT33_K;
         6'd10: op = OP_MUL_C1;
         6'd11: op = OP_H2_MIX;
         6'd12: op = OP_H2_X5;
         6'd13: op = OP_H2_ADD2;
         6'd14: op = OP_END_MIX;
         // tail words (zero when absent, and scramble of zero is zero)
         6'd15: op = OP_LOAD_K2;
         6'd16: op = OP_MUL_C2;
         6'd17: op = OP_ROT33_K;
         6'd18: op = OP_MUL_C1;
         6'd19: op = OP_H2_XK;
         6'd20: op = OP_LOAD_K1;
         6'd21: op = OP_MUL_C1;
         6'd22: op = OP_ROT31_K;
         6'd23: op = OP_MUL_C2;
         6'd24: op = OP_H1_XK;
         6'd25: op = OP_XLEN;
         6'd26: op = OP_H1_ADD_H2;
         6'd27: op = OP_H2_ADD_H1;
         // final mix of lane one
         6'd28: op = OP_K_H1;
         6'd29: op = OP_K_SHX;
         6'd30: op = OP_MUL_M1;
         6'd31: op = OP_K_SHX;
         6'd32: op = OP_MUL_M2;
         6'd33: op = OP_K_SHX;
         6'd34: op = OP_H1_K;
         // final mix of lane two
         6'd35: op = OP_K_H2;
         6'd36: op = OP_K_SHX;
         6'd37: op = OP_MUL_M1;
         6'd38: op = OP_K_SHX;
         6'd39: op = OP_MUL_M2;
         6'd40: op = OP_K_SHX;
         6'd41: op = OP_H2_K;
         6'd42: op = OP_H1_ADD_H2;
         6'd43: op = OP_H2_ADD_H1;
         default: op = OP_END_FIN;
      endcase
      return op;
   endfunction

   // Multiplier constant for each multiply op
   function automatic logic [63:0] mul_const(input op_type op);
      logic [63:0] c;
      case (op)
         OP_MUL_C1: c = MIX_C1;
         OP_MUL_C2: c = MIX_C2;
         OP_MUL_M1: c = FMIX_M1;
         OP_MUL_M2: c = FMIX_M2;
         default:   c = MIX_C1;
      endcase
      return c;
   endfunction

endpackage

[sv/murmur3_128_stream_hash.sv]
// Top level of the streaming 128-bit hash: byte collection, counters, output.
// Depends on mm3_pkg and mm3_engine.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall mm3_pkg::req_type (byte, has_byte, last)
//   rsp      out        rsp_valid/rsp_stall mm3_pkg::rsp_type (hash_low, hash_high)
//
// A byte that neither fills a block nor is last does not raise req_stall. The 16th byte
// of a block starts the microcoded engine, which holds req_stall high while it mixes the
// block; a last request holds it through finalization until the output register is free,
// after the block mix when its byte also fills a block. Each 64-bit multiply runs on the
// single 32x32 multiplier (issue, three partial products, result). Synchronous reset clears
// the lanes and counters. The digest sits in an output register while new bytes are
// accepted; a further digest waits in the engine until that register is free.
module murmur3_128_stream_hash (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mm3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mm3_pkg::rsp_type rsp_data
);

   logic [7:0]          block_ff [16];
   logic [3:0]          count_ff;
   logic [63:0]         length_ff;
   logic                rsp_valid_ff;
   mm3_pkg::rsp_type    rsp_data_ff;
   mm3_pkg::cmd_type    cmd;
   mm3_pkg::status_type status;
   logic                req_accept;
   logic                out_free;
   logic [63:0]         block_lo, block_hi;
   logic [63:0]         total_len;
   logic [63:0]         lane_one, lane_two;

   assign req_stall  = status.busy;
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign total_len  = length_ff + {60'd0, count_ff};

   // Block words, little-endian
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         block_lo[8*i +: 8] = block_ff[i];
         block_hi[8*i +: 8] = block_ff[i + 8];
      end
   end

   // Engine commands on each accepted request
   assign cmd.mix = req_accept && req_data.has_byte && (count_ff == 4'd15);
   assign cmd.fin = req_accept && req_data.last;

   mm3_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .block_lo   (block_lo),
      .block_hi   (block_hi),
      .tail_count (count_ff),
      .total_len  (total_len),
      .out_free   (out_free),
      .status     (status),
      .lane_one   (lane_one),
      .lane_two   (lane_two)
   );

   // Byte store, no reset
   always_ff @(posedge clock) begin
      if (req_accept && req_data.has_byte) begin
         block_ff[count_ff] <= req_data.data_byte;
      end
   end

   // Byte count and length of mixed blocks
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 4'd0;
         length_ff <= 64'd0;
      end else if (status.fin_done) begin
         count_ff  <= 4'd0;
         length_ff <= 64'd0;
      end else if (req_accept && req_data.has_byte) begin
         count_ff <= count_ff + 4'd1;
         if (count_ff == 4'd15) begin
            length_ff <= length_ff + 64'd16;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.fin_done) begin
         rsp_valid_ff          <= 1'b1;
         rsp_data_ff.hash_low  <= lane_one;
         rsp_data_ff.hash_high <= lane_two;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/mm3_mul.sv]
// Iterative 64x64 multiplier, low 64 product bits, one 32x32 multiplier.
// Takes no new start until the current product is done; depends on nothing outside this file.
module mm3_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] product
);

   logic [63:0] a_ff, b_ff;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff;
   logic [1:0]  step_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [31:0] op_x, op_y;

   // Partial product operand select
   always_comb begin
      case (step_ff)
         2'd0:    begin op_x = a_ff[31:0];  op_y = b_ff[31:0];  end
         2'd1:    begin op_x = a_ff[31:0];  op_y = b_ff[63:32]; end
         default: begin op_x = a_ff[63:32]; op_y = b_ff[31:0];  end
      endcase
   end

   // Product register, then accumulate the cross terms into the high half
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            a_ff    <= a;
            b_ff    <= b;
            step_ff <= 2'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            prod_ff <= op_x * op_y;
            step_ff <= step_ff + 2'd1;
            case (step_ff)
               2'd0: ;
               2'd1: acc_ff <= prod_ff;
               2'd2: acc_ff[63:32] <= acc_ff[63:32] + prod_ff[31:0];
               default: begin
                  acc_ff[63:32] <= acc_ff[63:32] + prod_ff[31:0];
                  busy_ff       <= 1'b0;
                  done_ff       <= 1'b1;
               end
            endcase
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

[sv/mm3_engine.sv]
// Microcoded engine: lane registers, scratch word and sequencer over mm3_mul.
// Depends on mm3_pkg and mm3_mul.
module mm3_engine (
   input  logic                clock,
   input  logic                reset,
   input  mm3_pkg::cmd_type    cmd,
   input  logic [63:0]         block_lo,
   input  logic [63:0]         block_hi,
   input  logic [3:0]          tail_count,
   input  logic [63:0]         total_len,
   input  logic                out_free,
   output mm3_pkg::status_type status,
   output logic [63:0]         lane_one,
   output logic [63:0]         lane_two
);

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_RUN,
      ENG_MUL,
      ENG_OUT
   } eng_state_type;

   eng_state_type   state_ff;
   logic [5:0]      pc_ff;
   logic            fin_pend_ff;
   logic [63:0]     h1_ff, h2_ff, k_ff;
   mm3_pkg::op_type op;
   logic            is_mul;
   logic            mul_start;
   logic            mul_done;
   logic [63:0]     mul_product;
   logic [63:0]     mask_lo, mask_hi;
   logic            fin_phase;
   logic [63:0]     t1, t2;

   assign op        = mm3_pkg::prog_op(pc_ff);
   assign is_mul    = op inside {mm3_pkg::OP_MUL_C1, mm3_pkg::OP_MUL_C2,
                                 mm3_pkg::OP_MUL_M1, mm3_pkg::OP_MUL_M2};
   assign mul_start = (state_ff == ENG_RUN) && is_mul;
   assign fin_phase = pc_ff >= mm3_pkg::FIN_START;
   assign t1        = h1_ff ^ k_ff;
   assign t2        = h2_ff ^ k_ff;

   // Keep only the tail bytes that belong to the message
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         mask_lo[8*i +: 8] = (5'(i) < {1'b0, tail_count}) ? 8'hff : 8'h00;
         mask_hi[8*i +: 8] = (5'(i + 8) < {1'b0, tail_count}) ? 8'hff : 8'h00;
      end
   end

   mm3_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (k_ff),
      .b       (mm3_pkg::mul_const(op)),
      .done    (mul_done),
      .product (mul_product)
   );

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ENG_IDLE;
         pc_ff       <= 6'd0;
         fin_pend_ff <= 1'b0;
         h1_ff       <= 64'd0;
         h2_ff       <= 64'd0;
      end else begin
         case (state_ff)
            ENG_IDLE: begin
               if (cmd.mix || cmd.fin) begin
                  pc_ff       <= cmd.mix ? 6'd0 : mm3_pkg::FIN_START;
                  fin_pend_ff <= cmd.fin;
                  state_ff    <= ENG_RUN;
               end
            end
            ENG_RUN: begin
               pc_ff <= pc_ff + 6'd1;
               case (op)
                  mm3_pkg::OP_LOAD_K1:
                     k_ff <= fin_phase ? (block_lo & mask_lo) : block_lo;
                  mm3_pkg::OP_LOAD_K2:
                     k_ff <= fin_phase ? (block_hi & mask_hi) : block_hi;
                  mm3_pkg::OP_MUL_C1, mm3_pkg::OP_MUL_C2,
                  mm3_pkg::OP_MUL_M1, mm3_pkg::OP_MUL_M2: begin
                     pc_ff    <= pc_ff;
                     state_ff <= ENG_MUL;
                  end
                  mm3_pkg::OP_ROT31_K:   k_ff  <= {k_ff[32:0], k_ff[63:33]};
                  mm3_pkg::OP_ROT33_K:   k_ff  <= {k_ff[30:0], k_ff[63:31]};
                  mm3_pkg::OP_H1_MIX:    h1_ff <= {t1[36:0], t1[63:37]} + h2_ff;
                  mm3_pkg::OP_H2_MIX:    h2_ff <= {t2[32:0], t2[63:33]} + h1_ff;
                  mm3_pkg::OP_H1_X5:     h1_ff <= {h1_ff[61:0], 2'b00} + h1_ff;
                  mm3_pkg::OP_H2_X5:     h2_ff <= {h2_ff[61:0], 2'b00} + h2_ff;
                  mm3_pkg::OP_H1_ADD1:   h1_ff <= h1_ff + mm3_pkg::LANE1_ADD;
                  mm3_pkg::OP_H2_ADD2:   h2_ff <= h2_ff + mm3_pkg::LANE2_ADD;
                  mm3_pkg::OP_H1_XK:     h1_ff <= t1;
                  mm3_pkg::OP_H2_XK:     h2_ff <= t2;
                  mm3_pkg::OP_XLEN: begin
                     h1_ff <= h1_ff ^ total_len;
                     h2_ff <= h2_ff ^ total_len;
                  end
                  mm3_pkg::OP_H1_ADD_H2: h1_ff <= h1_ff + h2_ff;
                  mm3_pkg::OP_H2_ADD_H1: h2_ff <= h2_ff + h1_ff;
                  mm3_pkg::OP_K_H1:      k_ff  <= h1_ff;
                  mm3_pkg::OP_K_H2:      k_ff  <= h2_ff;
                  mm3_pkg::OP_K_SHX:     k_ff  <= k_ff ^ {33'd0, k_ff[63:33]};
                  mm3_pkg::OP_H1_K:      h1_ff <= k_ff;
                  mm3_pkg::OP_H2_K:      h2_ff <= k_ff;
                  mm3_pkg::OP_END_MIX: begin
                     // a last byte that fills a block chains into finalization
                     if (fin_pend_ff) begin
                        pc_ff <= mm3_pkg::FIN_START;
                     end else begin
                        state_ff <= ENG_IDLE;
                     end
                  end
                  default: begin
                     pc_ff    <= pc_ff;
                     state_ff <= ENG_OUT;
                  end
               endcase
            end
            ENG_MUL: begin
               if (mul_done) begin
                  k_ff     <= mul_product;
                  pc_ff    <= pc_ff + 6'd1;
                  state_ff <= ENG_RUN;
               end
            end
            default: begin
               // hand the digest over, then back to the empty-message state
               if (out_free) begin
                  h1_ff       <= 64'd0;
                  h2_ff       <= 64'd0;
                  fin_pend_ff <= 1'b0;
                  state_ff    <= ENG_IDLE;
               end
            end
         endcase
      end
   end

   assign status.busy     = state_ff != ENG_IDLE;
   assign status.fin_done = (state_ff == ENG_OUT) && out_free;
   assign lane_one        = h1_ff;
   assign lane_two        = h2_ff;

endmodule

[sim/tb_murmur3_128_stream_hash.sv]
// Self-checking testbench for murmur3_128_stream_hash: byte-stream requests in, one
// 128-bit digest out per message, checked against an in-bench hash predictor.
// Depends on mm3_pkg (request/response types) and the RTL of the hash block.
module tb_murmur3_128_stream_hash;
   timeunit 1ns;
   timeprecision 1ps;

   // Hash constants, kept local so the predictor stands on its own
   localparam logic [63:0] HC_K1 = 64'h87c37b91114253d5;
   localparam logic [63:0] HC_K2 = 64'h4cf5ab172f4541a9;
   localparam logic [63:0] HC_F1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] HC_F2 = 64'hc4ceb9fe1a85ec53;
   localparam logic [63:0] HC_A1 = 64'h0000000052dce729;
   localparam logic [63:0] HC_A2 = 64'h0000000038495ab5;

   localparam int DRAIN_CYCLES = 150;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mm3_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mm3_pkg::rsp_type rsp_data;

   // Predictor state: two lanes, pending block bytes, fill count, mixed length
   logic [63:0] lane_h1 = '0;
   logic [63:0] lane_h2 = '0;
   logic [7:0]  pend_bytes [16];
   logic [3:0]  pend_count = '0;
   logic [63:0] mixed_len = '0;

   mm3_pkg::rsp_type expected_digests [$];
   int               mismatch_count = 0;
   int               sent_items = 0;
   bit               quiet_mode = 1'b0;

   always #4 clock = ~clock;

   murmur3_128_stream_hash u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int s);
      return (v << s) | (v >> (64 - s));
   endfunction

   function automatic logic [63:0] fmix64(input logic [63:0] k);
      k = k ^ (k >> 33);
      k = k * HC_F1;
      k = k ^ (k >> 33);
      k = k * HC_F2;
      k = k ^ (k >> 33);
      return k;
   endfunction

   function automatic logic [63:0] scramble_k1(input logic [63:0] k);
      k = k * HC_K1;
      k = rotl64(k, 31);
      return k * HC_K2;
   endfunction

   function automatic logic [63:0] scramble_k2(input logic [63:0] k);
      k = k * HC_K2;
      k = rotl64(k, 33);
      return k * HC_K1;
   endfunction

   // little-endian word from the pending block, count bytes starting at base
   function automatic logic [63:0] block_word(input int base, input int count);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < count; i++)
         w = w | (64'(pend_bytes[base + i]) << (8 * i));
      return w;
   endfunction

   // Fold one accepted request into the hash state; queue a digest on last
   task automatic absorb_request(input mm3_pkg::req_type r);
      logic [63:0]      h1;
      logic [63:0]      h2;
      logic [63:0]      msg_len;
      int               n;
      mm3_pkg::rsp_type digest;
      if (r.has_byte) begin
         pend_bytes[pend_count] = r.data_byte;
         pend_count = pend_count + 4'd1;
         // full block: mix both lanes
         if (pend_count == 4'd0) begin
            lane_h1 = lane_h1 ^ scramble_k1(block_word(0, 8));
            lane_h1 = rotl64(lane_h1, 27) + lane_h2;
            lane_h1 = lane_h1 * 64'd5 + HC_A1;
            lane_h2 = lane_h2 ^ scramble_k2(block_word(8, 8));
            lane_h2 = rotl64(lane_h2, 31) + lane_h1;
            lane_h2 = lane_h2 * 64'd5 + HC_A2;
            mixed_len = mixed_len + 64'd16;
         end
      end
      if (r.last) begin
         n  = int'(pend_count);
         h1 = lane_h1;
         h2 = lane_h2;
         // tail bytes, then length and final mix
         if (n > 8)
            h2 = h2 ^ scramble_k2(block_word(8, n - 8));
         if (n > 0)
            h1 = h1 ^ scramble_k1(block_word(0, (n > 8) ? 8 : n));
         msg_len = mixed_len + 64'(n);
         h1 = h1 ^ msg_len;
         h2 = h2 ^ msg_len;
         h1 = h1 + h2;
         h2 = h2 + h1;
         h1 = fmix64(h1);
         h2 = fmix64(h2);
         h1 = h1 + h2;
         h2 = h2 + h1;
         digest.hash_low  = h1;
         digest.hash_high = h2;
         expected_digests.push_back(digest);
         lane_h1    = '0;
         lane_h2    = '0;
         pend_count = '0;
         mixed_len  = '0;
      end
   endtask

   // ---------------------------------------------------------------- response side

   // receiver stalls in random bursts, none in quiet mode
   initial begin
      int run;
      forever begin
         run = $urandom_range(1, 24);
         repeat (run) @(posedge clock);
         if (!quiet_mode && $urandom_range(0, 1) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // compare each accepted digest with the oldest expected one
   always @(posedge clock) begin
      mm3_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digests.size() == 0) begin
            $error("unexpected digest: hash_low=%h hash_high=%h",
                   rsp_data.hash_low, rsp_data.hash_high);
            mismatch_count++;
         end else begin
            want = expected_digests.pop_front();
            if (rsp_data.hash_low !== want.hash_low) begin
               $error("hash_low: expected %h, actual %h", want.hash_low, rsp_data.hash_low);
               mismatch_count++;
            end
            if (rsp_data.hash_high !== want.hash_high) begin
               $error("hash_high: expected %h, actual %h", want.hash_high,
                      rsp_data.hash_high);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- request side

   // Drive one request, optionally after a random gap, and wait for acceptance
   task automatic send_request(input logic [7:0] data, input logic has_byte,
                               input logic is_last);
      mm3_pkg::req_type r;
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      r.data_byte = data;
      r.has_byte  = has_byte;
      r.last      = is_last;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      absorb_request(r);
      if (has_byte || is_last)
         sent_items++;
   endtask

   // One message of len bytes; last rides on the final byte or comes alone.
   // With stuffing, ignored requests are scattered through the message.
   task automatic send_message(input int len, input bit stuffing);
      bit joined;
      joined = (len > 0) && ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
         if (stuffing && $urandom_range(0, 3) == 0)
            send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1));
      end
      if (!joined)
         send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   function automatic int pick_length();
      if ($urandom_range(0, 9) < 7)
         return $urandom_range(0, 33);
      return $urandom_range(34, 80);
   endfunction

   // hold the request side until every expected digest has arrived
   task automatic wait_digests_out();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_digests.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // empty message, ignored request, byte with last, block completed by last byte
   task automatic test_edge_messages();
      logic [7:0] b;
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hA5, 1'b0, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);
      for (int i = 0; i < 16; i++) begin
         b = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'(i * 37);
         send_request(b, 1'b1, i == 15);
      end
   endtask

   task automatic test_random_messages(input int target);
      while (sent_items < target)
         send_message(pick_length(), 1'b0);
   endtask

   // sender stops after each message until the digest is back
   task automatic test_drain_between_messages();
      for (int m = 0; m < 6; m++) begin
         send_message(pick_length(), 1'b0);
         wait_digests_out();
      end
   endtask

   // several blocks per message
   task automatic test_long_messages();
      send_message($urandom_range(160, 260), 1'b0);
      send_message(16 * $urandom_range(8, 12), 1'b0);
   endtask

   // messages with ignored requests mixed in, plus runs of noise alone
   task automatic test_ignored_requests(input int target);
      while (sent_items < target) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6))
               send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_message(pick_length(), 1'b1);
      end
   endtask

   // no idling on either side
   task automatic test_back_to_back(input int target);
      quiet_mode = 1'b1;
      while (sent_items < target)
         send_message(pick_length(), $urandom_range(0, 3) == 0);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_messages();
      test_random_messages(670);
      test_drain_between_messages();
      test_long_messages();
      test_ignored_requests(sent_items + 200);
      test_back_to_back(sent_items + 150);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_digests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

[murmur3_128_stream_hash.f]
sv/mm3_pkg.sv
sv/mm3_mul.sv
sv/mm3_engine.sv
sv/murmur3_128_stream_hash.sv
sim/tb_murmur3_128_stream_hash.sv
